@@ rtl/sitda_pkg.sv @@
// Shared constants, types and a helper function for the signed decimal text formatter.
package sitda_pkg;

    localparam int VALUE_PORT_WIDTH    = 64;
    localparam int VALUE_WIDTH_DEFAULT = 64;
    localparam int CHAR_WIDTH          = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SUFFIX = 8'h6C;

    localparam logic [3:0] DIGIT_NINE = 4'd9;

    // Decimal digits of 2^(width-1), the largest magnitude a signed value can have.
    function automatic int digits_for(input int width);
        return (((width - 1) * 1233) >>> 12) + 1;
    endfunction

    typedef struct packed {
        logic busy;
        logic done;
    } dab_status_t;

endpackage

@@ rtl/sitda_dabble.sv @@
// Bit-serial binary to BCD converter, one magnitude bit shifted in per cycle.
module sitda_dabble #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEFAULT,
    parameter int DIGITS      = sitda_pkg::digits_for(VALUE_WIDTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  mag,
    output logic [4*DIGITS-1:0]     bcd,
    output sitda_pkg::dab_status_t  status
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] bin_reg;
    logic [VALUE_WIDTH-1:0] bin_next;
    logic [4*DIGITS-1:0]    bcd_reg;
    logic [4*DIGITS-1:0]    bcd_next;
    logic [4*DIGITS-1:0]    adj;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;

    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] > 4'd4)
            begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[4*DIGITS-2:0], bin_reg[VALUE_WIDTH-1]};
            bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd         = bcd_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

@@ rtl/sitda_emit.sv @@
// Character sequencer: sign, digits without leading zeros, suffix, through an output register.
module sitda_emit #(
    parameter int DIGITS = sitda_pkg::digits_for(sitda_pkg::VALUE_WIDTH_DEFAULT)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sitda_pkg::dab_status_t          conv,
    input  logic [4*DIGITS-1:0]             bcd,
    input  logic                            negative,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sitda_pkg::CHAR_WIDTH-1:0] character,
    output logic                            last
);

    localparam int IDX_W = $clog2(DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_SKIP,
        S_DIGIT,
        S_SUFFIX
    } state_t;

    state_t                          state_reg;
    logic [4*DIGITS-1:0]             dig_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic                            out_valid_reg;
    logic [sitda_pkg::CHAR_WIDTH-1:0] char_reg;
    logic                            last_reg;
    logic                            slot_free;
    logic                            out_load;
    logic [3:0]                      top_digit;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_load  = slot_free && (state_reg == S_SIGN || state_reg == S_DIGIT
                                     || state_reg == S_SUFFIX);
    assign top_digit = dig_reg[4*DIGITS-1 -: 4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dig_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (conv.done)
                    begin
                        dig_reg   <= bcd;
                        idx_reg   <= IDX_W'(DIGITS - 1);
                        state_reg <= negative ? S_SIGN : S_SKIP;
                    end
                end
                S_SIGN:
                begin
                    if (slot_free)
                    begin
                        char_reg      <= sitda_pkg::CHAR_MINUS;
                        last_reg      <= 1'b0;
                        state_reg     <= S_SKIP;
                    end
                end
                S_SKIP:
                begin
                    if (top_digit == 4'd0 && idx_reg != '0)
                    begin
                        dig_reg <= {dig_reg[4*DIGITS-5:0], 4'h0};
                        idx_reg <= idx_reg - IDX_W'(1);
                    end
                    else
                    begin
                        state_reg <= S_DIGIT;
                    end
                end
                S_DIGIT:
                begin
                    if (slot_free)
                    begin
                        char_reg      <= sitda_pkg::CHAR_ZERO | {4'h0, top_digit};
                        last_reg      <= 1'b0;
                        dig_reg       <= {dig_reg[4*DIGITS-5:0], 4'h0};
                        if (idx_reg == '0)
                        begin
                            state_reg <= S_SUFFIX;
                        end
                        else
                        begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                end
                S_SUFFIX:
                begin
                    if (slot_free)
                    begin
                        char_reg      <= sitda_pkg::CHAR_SUFFIX;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

@@ rtl/signed_int_to_decimal_ascii_core.sv @@
// Top level of the signed integer to decimal ASCII text formatter.
// Each accepted value (low VALUE_WIDTH bits, two's complement) comes out as a run of
// beats: '-' when negative, the decimal digits with no leading zeros ('0' for zero),
// then 'l' with last high. The magnitude is converted one bit per cycle by a
// shift-and-add-3 BCD register, which then hands the digits over; leading zero digits
// are then dropped at one per cycle, scanning down from the top of the DIGITS digits
// (19 at the default width) and stopping at the first nonzero digit or the last one,
// and each character is sent as its own beat from the output register. One value is
// in flight at a time: in_ready rises the cycle after the final beat is taken.
module signed_int_to_decimal_ascii_core #(
    parameter int VALUE_WIDTH = sitda_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [sitda_pkg::VALUE_PORT_WIDTH-1:0] value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [sitda_pkg::CHAR_WIDTH-1:0]        character,
    output logic                                   last
);

    localparam int DIGITS = sitda_pkg::digits_for(VALUE_WIDTH);

    logic                   busy_reg;
    logic                   neg_reg;
    logic                   accept;
    logic                   final_beat;
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [4*DIGITS-1:0]    bcd;
    sitda_pkg::dab_status_t conv;

    assign in_ready   = !busy_reg;
    assign accept     = in_valid && in_ready;
    assign final_beat = out_valid && out_ready && last;
    assign raw        = value[VALUE_WIDTH-1:0];
    assign mag        = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= raw[VALUE_WIDTH-1];
            end
            else if (final_beat)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    sitda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIGITS      (DIGITS)
    ) u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mag    (mag),
        .bcd    (bcd),
        .status (conv)
    );

    sitda_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .conv      (conv),
        .bcd       (bcd),
        .negative  (neg_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

`ifndef ASSERT_OFF
    a_conv_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(conv.busy && out_valid))
        else $error("conversion running while a character beat is pending");

    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        final_beat |=> in_ready)
        else $error("not ready after final beat");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (character == sitda_pkg::CHAR_MINUS
                       || character == sitda_pkg::CHAR_SUFFIX
                       || (character[7:4] == 4'h3
                           && character[3:0] <= sitda_pkg::DIGIT_NINE)))
        else $error("illegal character on output");

    a_last_is_suffix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (character == sitda_pkg::CHAR_SUFFIX))
        else $error("last flag on a character other than the suffix");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the signed integer to decimal ASCII text formatter.
`timescale 1ns / 100ps

module testbench;

    class decimal_text_scoreboard;
        typedef struct {
            logic [sitda_pkg::CHAR_WIDTH-1:0] character;
            logic                             last;
        } text_beat_t;

        text_beat_t  pending_chars[$];
        int unsigned failures;
        int unsigned values_seen;
        int unsigned negatives_seen;
        int unsigned chars_checked;
        int unsigned longest_text;

        function new();
            failures       = 0;
            values_seen    = 0;
            negatives_seen = 0;
            chars_checked  = 0;
            longest_text   = 0;
        endfunction

        // Render the accepted value as '-' when negative, then digits most significant first, then the suffix.
        function void note_value(logic [sitda_pkg::VALUE_PORT_WIDTH-1:0] v);
            bit                                   is_neg;
            bit [sitda_pkg::VALUE_PORT_WIDTH-1:0] magnitude;
            bit [3:0]                             digits[$];
            text_beat_t                           b;
            int unsigned                          text_len;
            is_neg    = v[sitda_pkg::VALUE_PORT_WIDTH-1];
            magnitude = is_neg ? (~v + 64'd1) : v;
            do
            begin
                digits.push_back(4'(magnitude % 64'd10));
                magnitude = magnitude / 64'd10;
            end
            while (magnitude != 0);
            if (is_neg)
            begin
                b.character = sitda_pkg::CHAR_MINUS;
                b.last      = 1'b0;
                pending_chars.push_back(b);
                negatives_seen++;
            end
            for (int i = digits.size() - 1; i >= 0; i--)
            begin
                b.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_WIDTH'(digits[i]);
                b.last      = 1'b0;
                pending_chars.push_back(b);
            end
            b.character = sitda_pkg::CHAR_SUFFIX;
            b.last      = 1'b1;
            pending_chars.push_back(b);
            text_len = digits.size() + (is_neg ? 2 : 1);
            if (text_len > longest_text)
                longest_text = text_len;
            values_seen++;
        endfunction

        function void check_char(logic [sitda_pkg::CHAR_WIDTH-1:0] ch, logic lst);
            text_beat_t e;
            chars_checked++;
            if (pending_chars.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: unexpected beat character=%h last=%b", $time, ch, lst);
                return;
            end
            e = pending_chars.pop_front();
            if (ch !== e.character || lst !== e.last)
            begin
                failures++;
                if (failures <= 10)
                    $display("%0t: mismatch character exp=%h got=%h, last exp=%b got=%b",
                             $time, e.character, ch, e.last, lst);
            end
        endfunction
    endclass

    logic                                   clk;
    logic                                   rst_n     = 1'b0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_ready;
    logic [sitda_pkg::VALUE_PORT_WIDTH-1:0] value     = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic [sitda_pkg::CHAR_WIDTH-1:0]       character;
    logic                                   last;

    decimal_text_scoreboard sb = new();
    bit                     gaps_on       = 1'b1;
    bit                     stalls_on     = 1'b1;
    bit                     hold_request  = 1'b0;

    signed_int_to_decimal_ascii_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_char(character, last);
    end

    // Receiver: random stalls, always ready when stalls are off, or a long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = 500;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!stalls_on)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 35);
        end
    end

    task automatic send_value(input logic [sitda_pkg::VALUE_PORT_WIDTH-1:0] v);
        if (gaps_on)
        begin
            while ($urandom_range(99) < 35)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_value(v);
    endtask

    function automatic logic [63:0] power_of_ten(int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++)
            p = p * 64'd10;
        return p;
    endfunction

    task automatic send_random_value();
        logic [63:0] raw;
        logic [63:0] v;
        int          kind;
        int          n;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(99);
        n    = $urandom_range(18, 1);
        if (kind < 40)
            v = raw;
        else if (kind < 80)
            v = raw % power_of_ten(n);
        else
            v = power_of_ten(n) + 64'($urandom_range(2)) - 64'd1;
        if (kind >= 40 && $urandom_range(1))
            v = -v;
        send_value(v);
    endtask

    initial
    begin
        logic [63:0] directed[$];
        directed = '{
            64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
            -64'd100, 64'd12345, -64'd67890,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFE,
            64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'd1000000000000000000, 64'd999999999999999999, -64'd1000000000000000000,
            64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_value(directed[i]);

        for (int k = 0; k < 350; k++)
        begin
            if (k == 60)
                hold_request = 1'b1;
            if (k == 150)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (k == 230)
            begin
                gaps_on   = 1'b1;
                stalls_on = 1'b1;
            end
            send_random_value();
        end
        in_valid <= 1'b0;

        while (sb.pending_chars.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("Formatted %0d values (%0d negative) into %0d checked characters,",
                 sb.values_seen, sb.negatives_seen, sb.chars_checked);
        $display("longest text %0d characters, %0d failures.", sb.longest_text, sb.failures);
        if (sb.failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ signed_int_to_decimal_ascii_core.f @@
rtl/sitda_pkg.sv
rtl/sitda_dabble.sv
rtl/sitda_emit.sv
rtl/signed_int_to_decimal_ascii_core.sv
tb/testbench.sv
